>>> rtl/core/wdw_pkg.sv
`timescale 1ns / 1ps
// Package for the wave displacement warp core: item structs, register indexes and
// the fixed-point sine polynomial coefficients. No dependencies.
package wdw_pkg;

  // One input item: a pixel write or a warped pixel read.
  typedef struct packed {
    logic        kind;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
    logic [31:0] alpha_in;
  } in_item_t;

  // One result item: the clamped source coordinate and the stored pixel there.
  typedef struct packed {
    logic [7:0]  source_x;
    logic [7:0]  source_y;
    logic [31:0] red_out;
    logic [31:0] green_out;
    logic [31:0] blue_out;
    logic [31:0] alpha_out;
  } out_item_t;

  // One stored pixel, as it sits in the frame store.
  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

  // Configuration register set.
  typedef struct packed {
    logic signed [15:0] amplitude;
    logic [15:0]        frequency;
    logic [15:0]        phase;
    logic               wave_type;
    logic               orientation;
    logic [8:0]         image_width;
    logic [8:0]         image_height;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_AMPLITUDE    = 3'd0,
    REG_FREQUENCY    = 3'd1,
    REG_PHASE        = 3'd2,
    REG_WAVE_TYPE    = 3'd3,
    REG_ORIENTATION  = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } reg_index_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic WAVE_SINE       = 1'b0;
  localparam logic ORIENT_VERTICAL = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // Odd polynomial for a quarter sine wave, Q16 coefficients.
  localparam logic [16:0] SIN_C1 = 17'd102944;
  localparam logic [15:0] SIN_C3 = 16'd42048;
  localparam logic [12:0] SIN_C5 = 13'd4640;

endpackage

>>> rtl/core/wave_displacement_warp_core.sv
`timescale 1ns / 1ps
// Top level of the sine wave displacement warp core: configuration registers,
// front pipeline, queue and back half. Depends on wdw_pkg, wdw_front, wdw_fifo, wdw_back.
//
// Usage:
//   Input items arrive on in_item and are taken at each rising edge where start is
//   high and busy is low. A write item (kind = 0) stores one RGBA pixel in the frame
//   store; a read item (kind = 1) names a destination pixel and produces one result.
//   Results appear on out_item for exactly one cycle, marked by out_strobe. The
//   receiver cannot hold results off, so the back half drains the queue every cycle.
//   Throughput is one item per clock. A read item accepted at a rising edge passes
//   through seven front stages (angle, square, three polynomial multiplies,
//   amplitude scale, clamp), one queue slot and the registered read of the frame
//   store before its result appears on out_item. Writes take the same path, so a
//   read sees every write accepted before it. busy rises only if the queue fills.
//   Configuration registers are written through cfg_valid/cfg_ready with cfg_index
//   and cfg_data; cfg_ready is always high, indexes past the list are ignored, and
//   writes belong in idle periods. Synchronous reset clears the pipeline and the
//   queue and loads the register defaults; the frame store is not cleared, and a read
//   of a pixel never written returns undefined data.
module wave_displacement_warp_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wdw_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output wdw_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int QW = 2 + XW + YW + wdw_pkg::PIX_W;

  wdw_pkg::cfg_t    cfg_r, cfg_nxt;

  logic             f_valid, f_is_read, f_wr_ok;
  logic [XW-1:0]    f_cx;
  logic [YW-1:0]    f_cy;
  wdw_pkg::pixel_t  f_pix;

  logic             q_push, q_pop, q_empty, q_full;
  logic [QW-1:0]    q_wdata, q_rdata;

  logic             b_is_read, b_wr_ok;
  logic [XW-1:0]    b_cx;
  logic [YW-1:0]    b_cy;
  wdw_pkg::pixel_t  b_pix;

  logic             rd_accept;

  // Configuration register file; each write lands in cfg_r in the cycle after it is presented.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        wdw_pkg::REG_AMPLITUDE:    cfg_nxt.amplitude    = $signed(cfg_data);
        wdw_pkg::REG_FREQUENCY:    cfg_nxt.frequency    = cfg_data;
        wdw_pkg::REG_PHASE:        cfg_nxt.phase        = cfg_data;
        wdw_pkg::REG_WAVE_TYPE:    cfg_nxt.wave_type    = cfg_data[0];
        wdw_pkg::REG_ORIENTATION:  cfg_nxt.orientation  = cfg_data[0];
        wdw_pkg::REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data[8:0];
        wdw_pkg::REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data[8:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amplitude    <= '0;
      cfg_r.frequency    <= '0;
      cfg_r.phase        <= '0;
      cfg_r.wave_type    <= wdw_pkg::WAVE_SINE;
      cfg_r.orientation  <= 1'b0;
      cfg_r.image_width  <= 9'd256;
      cfg_r.image_height <= 9'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The whole front pipeline moves as one while the queue has room.
  assign busy = q_full;

  wdw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .in_item   (in_item),
    .adv       (!q_full),
    .f_valid   (f_valid),
    .f_is_read (f_is_read),
    .f_wr_ok   (f_wr_ok),
    .f_cx      (f_cx),
    .f_cy      (f_cy),
    .f_pix     (f_pix)
  );

  // Queue entry: operation, write-in-range flag, coordinate and pixel data.
  assign q_push  = f_valid && !q_full;
  assign q_wdata = {f_is_read, f_wr_ok, f_cx, f_cy, f_pix};

  wdw_fifo #(
    .WIDTH (QW),
    .DEPTH (wdw_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  assign {b_is_read, b_wr_ok, b_cx, b_cy, b_pix} = q_rdata;

  wdw_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_is_read  (b_is_read),
    .q_wr_ok    (b_wr_ok),
    .q_cx       (b_cx),
    .q_cy       (b_cy),
    .q_pix      (b_pix),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  assign rd_accept = start && !busy && (in_item.kind == wdw_pkg::KIND_READ);

  // Since the back half drains every cycle, the path has a fixed latency.
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_accept |-> ##9 out_strobe)
    else $error("accepted read item produced no result");

  a_result_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rd_accept, 9))
    else $error("result item without a matching read item");

  // The queue holds at most one entry, so the input is never held off.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled although the back half drains every cycle");

endmodule

>>> rtl/core/wdw_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module wdw_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/wdw_fifo.sv
`timescale 1ns / 1ps
// Short show-ahead queue between the front and back halves of the warp core.
// No dependencies.
module wdw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue fill count lost an item");

endmodule

>>> rtl/core/wdw_front.sv
`timescale 1ns / 1ps
// Front half of the warp core: accepts items and computes the clamped source
// coordinate in a seven-stage pipeline. Depends on wdw_pkg.
module wdw_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ANGLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wdw_pkg::cfg_t                 cfg,
  input  logic                          start,
  input  wdw_pkg::in_item_t             in_item,
  input  logic                          adv,
  output logic                          f_valid,
  output logic                          f_is_read,
  output logic                          f_wr_ok,
  output logic [$clog2(MAX_WIDTH)-1:0]  f_cx,
  output logic [$clog2(MAX_HEIGHT)-1:0] f_cy,
  output wdw_pkg::pixel_t               f_pix
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CMW = (XW > YW) ? XW : YW;
  localparam int SW  = ((CMW > 10) ? CMW : 10) + 2;
  localparam logic [ANGLE_BITS-1:0] QTURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                    acc;
  logic [6:0]              v_r;
  wdw_pkg::in_item_t       itm_r [0:6];

  logic [15:0]             ang_r, ang_nxt;
  logic [16:0]             u_r [1:3];
  logic [16:0]             u2_r [1:2];
  logic [1:0]              quad_r [1:4];
  logic [12:0]             t1_r;
  logic [15:0]             t2_r;
  logic [16:0]             mag_r;
  logic [9:0]              m_r;
  logic                    neg_r;
  logic [XW-1:0]           cx_r;
  logic [YW-1:0]           cy_r;
  logic                    wok_r;

  logic [7:0]              coord_in;
  logic [23:0]             ang_ext;
  logic [ANGLE_BITS-1:0]   angle;
  logic [ANGLE_BITS+13:0]  frac_ext;
  logic [15:0]             u16;
  logic [1:0]              quad_nxt;
  logic [16:0]             u_nxt, u2_nxt;
  logic [33:0]             p_b;
  logic [29:0]             p_c;
  logic [12:0]             t1_nxt;
  logic [15:0]             diff_d;
  logic [32:0]             p_d;
  logic [15:0]             t2_nxt;
  logic [16:0]             diff_e;
  logic [33:0]             p_e;
  logic [16:0]             mag_nxt;
  logic [15:0]             amp_mag;
  logic [32:0]             p_f;
  logic [9:0]              m_nxt;
  logic                    neg_nxt;
  logic [XW-1:0]           w_m1;
  logic [YW-1:0]           h_m1;
  logic signed [SW-1:0]    m_ext, offs, sx, sy;
  logic [XW-1:0]           cx_nxt;
  logic [YW-1:0]           cy_nxt;
  logic                    wok_nxt;

  assign acc = start && adv;

  // Stage A: turn angle, frequency * coordinate + phase, modulo one turn.
  always_comb begin
    coord_in = (cfg.orientation == wdw_pkg::ORIENT_VERTICAL) ? in_item.y_pos : in_item.x_pos;
    ang_nxt  = 16'(32'(cfg.frequency) * 32'(coord_in) + 32'(cfg.phase));
  end

  // Stage B: quadrant, folded quarter fraction and its square.
  always_comb begin
    ang_ext = {ang_r, 8'h00};
    angle   = ang_ext[23 -: ANGLE_BITS];
    if (cfg.wave_type != wdw_pkg::WAVE_SINE) begin
      angle = angle + QTURN;
    end
    quad_nxt = angle[ANGLE_BITS-1 -: 2];
    frac_ext = {angle[ANGLE_BITS-3:0], 16'h0000};
    u16      = frac_ext[ANGLE_BITS+13 -: 16];
    u_nxt    = quad_nxt[0] ? (17'h10000 - {1'b0, u16}) : {1'b0, u16};
    p_b      = 34'(u_nxt) * 34'(u_nxt);
    u2_nxt   = p_b[32:16];
  end

  // Stages C through E: Horner evaluation of the sine polynomial.
  always_comb begin
    p_c     = 30'(wdw_pkg::SIN_C5) * 30'(u2_r[1]);
    t1_nxt  = p_c[28:16];
    diff_d  = wdw_pkg::SIN_C3 - {3'b000, t1_r};
    p_d     = 33'(diff_d) * 33'(u2_r[2]);
    t2_nxt  = p_d[31:16];
    diff_e  = wdw_pkg::SIN_C1 - {1'b0, t2_r};
    p_e     = 34'(diff_e) * 34'(u_r[3]);
    mag_nxt = p_e[32:16];
  end

  // Stage F: scale by the amplitude magnitude; the sign is kept apart so the
  // shift truncates toward zero.
  always_comb begin
    amp_mag = cfg.amplitude[15] ? (~cfg.amplitude + 16'd1) : cfg.amplitude;
    p_f     = 33'(amp_mag) * 33'(mag_r);
    m_nxt   = p_f[31:22];
    neg_nxt = quad_r[4][1] ^ cfg.amplitude[15];
  end

  // Stage G: for a read, displace one coordinate and clamp both to the image in use; writes pass through.
  always_comb begin
    if (cfg.image_width == 9'd0) begin
      w_m1 = '0;
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w_m1 = XW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = XW'(cfg.image_width - 9'd1);
    end
    if (cfg.image_height == 9'd0) begin
      h_m1 = '0;
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      h_m1 = YW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = YW'(cfg.image_height - 9'd1);
    end

    m_ext = $signed(SW'(m_r));
    offs  = neg_r ? -m_ext : m_ext;
    sx    = $signed(SW'(itm_r[5].x_pos));
    sy    = $signed(SW'(itm_r[5].y_pos));
    if (cfg.orientation == wdw_pkg::ORIENT_VERTICAL) begin
      sy = sy + offs;
    end else begin
      sx = sx + offs;
    end

    wok_nxt = (32'(itm_r[5].x_pos) < 32'(MAX_WIDTH)) &&
              (32'(itm_r[5].y_pos) < 32'(MAX_HEIGHT));

    if (itm_r[5].kind == wdw_pkg::KIND_WRITE) begin
      cx_nxt = XW'(itm_r[5].x_pos);
      cy_nxt = YW'(itm_r[5].y_pos);
    end else begin
      if (sx < 0) begin
        cx_nxt = '0;
      end else if (sx > $signed(SW'(w_m1))) begin
        cx_nxt = w_m1;
      end else begin
        cx_nxt = XW'(sx);
      end
      if (sy < 0) begin
        cy_nxt = '0;
      end else if (sy > $signed(SW'(h_m1))) begin
        cy_nxt = h_m1;
      end else begin
        cy_nxt = YW'(sy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm_r[0] <= in_item;
      for (int i = 1; i < 7; i++) begin
        itm_r[i] <= itm_r[i-1];
      end
      ang_r     <= ang_nxt;
      u_r[1]    <= u_nxt;
      u_r[2]    <= u_r[1];
      u_r[3]    <= u_r[2];
      u2_r[1]   <= u2_nxt;
      u2_r[2]   <= u2_r[1];
      quad_r[1] <= quad_nxt;
      quad_r[2] <= quad_r[1];
      quad_r[3] <= quad_r[2];
      quad_r[4] <= quad_r[3];
      t1_r      <= t1_nxt;
      t2_r      <= t2_nxt;
      mag_r     <= mag_nxt;
      m_r       <= m_nxt;
      neg_r     <= neg_nxt;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      wok_r     <= wok_nxt;
    end
  end

  assign f_valid   = v_r[6];
  assign f_is_read = (itm_r[6].kind == wdw_pkg::KIND_READ);
  assign f_wr_ok   = wok_r;
  assign f_cx      = cx_r;
  assign f_cy      = cy_r;
  assign f_pix     = '{red:   itm_r[6].red_in,
                       green: itm_r[6].green_in,
                       blue:  itm_r[6].blue_in,
                       alpha: itm_r[6].alpha_in};

endmodule

>>> rtl/core/wdw_back.sv
`timescale 1ns / 1ps
// Back half of the warp core: carries out queued writes and reads on the frame
// store and drives the result item. Depends on wdw_pkg and wdw_ram.
module wdw_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic                          q_is_read,
  input  logic                          q_wr_ok,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_cx,
  input  logic [$clog2(MAX_HEIGHT)-1:0] q_cy,
  input  wdw_pkg::pixel_t               q_pix,
  output logic                          q_pop,
  output logic                          out_strobe,
  output wdw_pkg::out_item_t            out_item
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [AW-1:0]            addr;
  logic                     we, re;
  logic [wdw_pkg::PIX_W-1:0] rdata;
  wdw_pkg::pixel_t          rpix;
  logic                     rd_v_r;
  logic [XW-1:0]            cx_r;
  logic [YW-1:0]            cy_r;

  // The back half never stalls, so every queued item is taken at once.
  assign q_pop = q_valid;
  assign addr  = AW'(q_cy) * AW'(MAX_WIDTH) + AW'(q_cx);
  assign we    = q_valid && !q_is_read && q_wr_ok;
  assign re    = q_valid && q_is_read;

  wdw_ram #(
    .WIDTH (wdw_pkg::PIX_W),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (q_pix),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= re;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      cx_r <= q_cx;
      cy_r <= q_cy;
    end
  end

  assign rpix       = rdata;
  assign out_strobe = rd_v_r;

  always_comb begin
    out_item.source_x  = 8'(cx_r);
    out_item.source_y  = 8'(cy_r);
    out_item.red_out   = rpix.red;
    out_item.green_out = rpix.green;
    out_item.blue_out  = rpix.blue;
    out_item.alpha_out = rpix.alpha;
  end

endmodule
